// ===== design/stack_with_index_read_and_search_unit_assert.svh =====
`ifndef STACK_WITH_INDEX_READ_AND_SEARCH_UNIT_ASSERT_SVH
`define STACK_WITH_INDEX_READ_AND_SEARCH_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define STK_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define STK_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/stk_pkg.sv =====
package stk_pkg;

    localparam int DEPTH   = 256;
    localparam int WORD_W  = 32;
    localparam int POS_W   = 8;
    localparam int CNT_W   = 9;
    localparam int ACT_W   = 2;
    localparam int STAT_W  = 3;
    localparam int ADDR_W  = 3;
    localparam int PDATA_W = 32;

    localparam logic [ACT_W-1:0] ACT_PUSH   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_POP    = 2'd1;
    localparam logic [ACT_W-1:0] ACT_READ   = 2'd2;
    localparam logic [ACT_W-1:0] ACT_SEARCH = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd2;
    localparam logic [STAT_W-1:0] ST_RANGE    = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd4;

    localparam logic [ADDR_W-1:0] REG_CAPACITY = 3'd0;
    localparam logic [CNT_W-1:0]  CAP_RESET    = 9'd256;

    typedef struct packed {
        logic push;
        logic pop;
    } ctl_t;

    // query transaction walking the cell row
    typedef struct packed {
        logic              valid;
        logic              is_search;
        logic [WORD_W-1:0] word;
        logic [POS_W-1:0]  target;
        logic              hit;
        logic [POS_W-1:0]  idx;
    } tok_t;

endpackage

// ===== design/stack_with_index_read_and_search_unit.sv =====
// push, pop, out-of-range read: accepted every cycle unless busy, result in the next cycle
// in-range read and search: a query walks the 256-cell row one cell per cycle, result
// registered after the last cell; busy stays high until then, so no new request is taken
// meanwhile; results cannot be stalled: done marks each result for exactly one cycle
// async reset (rst_n low): count zero, capacity 256, no query in flight; stored words
// stay undefined until pushed
`include "stack_with_index_read_and_search_unit_assert.svh"

module stack_with_index_read_and_search_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [stk_pkg::ACT_W-1:0]   action,
    input  logic signed [stk_pkg::WORD_W-1:0] value,
    input  logic [stk_pkg::POS_W-1:0]   position,
    output logic                        done,
    output logic [stk_pkg::STAT_W-1:0]  status,
    output logic signed [stk_pkg::WORD_W-1:0] data_out,
    output logic [stk_pkg::POS_W-1:0]   found_at,
    output logic [stk_pkg::CNT_W-1:0]   occupancy,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [stk_pkg::ADDR_W-1:0]  paddr,
    input  logic [stk_pkg::PDATA_W-1:0] pwdata,
    output logic [stk_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);

    localparam logic [stk_pkg::CNT_W-1:0] DEPTH_C = stk_pkg::CNT_W'(stk_pkg::DEPTH);

    logic [stk_pkg::CNT_W-1:0]  capacity;
    logic [stk_pkg::CNT_W-1:0]  eff_cap;
    logic [stk_pkg::CNT_W-1:0]  count_reg;
    logic [stk_pkg::CNT_W-1:0]  count_next;
    logic                       busy_reg;
    logic                       busy_next;
    logic                       done_reg;
    logic                       done_next;
    logic [stk_pkg::STAT_W-1:0] status_reg;
    logic [stk_pkg::STAT_W-1:0] status_next;
    logic [stk_pkg::WORD_W-1:0] data_reg;
    logic [stk_pkg::WORD_W-1:0] data_next;
    logic [stk_pkg::POS_W-1:0]  found_reg;
    logic [stk_pkg::POS_W-1:0]  found_next;
    logic [stk_pkg::CNT_W-1:0]  occ_reg;
    logic [stk_pkg::CNT_W-1:0]  occ_next;

    logic                       accept;
    logic                       push_ok;
    logic                       pop_ok;
    logic                       read_ok;
    logic                       launch;
    logic [stk_pkg::CNT_W-1:0]  read_cell;
    logic [stk_pkg::CNT_W-1:0]  found_pos;
    stk_pkg::ctl_t              ctl;
    stk_pkg::tok_t              entry_tok;
    stk_pkg::tok_t              last_tok;

    logic [stk_pkg::WORD_W-1:0] cell_word [stk_pkg::DEPTH];
    stk_pkg::tok_t              chain     [stk_pkg::DEPTH];

    stk_apb u_apb (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .capacity (capacity)
    );

    assign eff_cap = (capacity > DEPTH_C) ? DEPTH_C : capacity;

    assign accept    = start && !busy_reg;
    assign push_ok   = accept && (action == stk_pkg::ACT_PUSH) && (count_reg < eff_cap);
    assign pop_ok    = accept && (action == stk_pkg::ACT_POP) && (count_reg != '0);
    assign read_ok   = accept && (action == stk_pkg::ACT_READ)
                       && ({1'b0, position} < count_reg);
    assign launch    = (accept && (action == stk_pkg::ACT_SEARCH)) || read_ok;
    // cell 0 holds the top of the stack
    assign read_cell = count_reg - {1'b0, position} - 1'b1;

    assign ctl.push = push_ok;
    assign ctl.pop  = pop_ok;

    always_comb
    begin
        entry_tok.valid     = launch;
        entry_tok.is_search = (action == stk_pkg::ACT_SEARCH);
        entry_tok.word      = value;
        entry_tok.target    = read_cell[stk_pkg::POS_W-1:0];
        entry_tok.hit       = 1'b0;
        entry_tok.idx       = '0;
    end

    genvar j;
    generate
        for (j = 0; j < stk_pkg::DEPTH; j++)
        begin : g_cell
            logic [stk_pkg::WORD_W-1:0] up_w;
            logic [stk_pkg::WORD_W-1:0] down_w;
            stk_pkg::tok_t              tin;

            if (j == 0)
            begin : g_first
                assign up_w = value;
                assign tin  = entry_tok;
            end
            else
            begin : g_mid
                assign up_w = cell_word[j-1];
                assign tin  = chain[j-1];
            end

            if (j == stk_pkg::DEPTH - 1)
            begin : g_last
                assign down_w = '0;
            end
            else
            begin : g_down
                assign down_w = cell_word[j+1];
            end

            stk_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctl       (ctl),
                .up_word   (up_w),
                .down_word (down_w),
                .cell_idx  (stk_pkg::POS_W'(j)),
                .count     (count_reg),
                .tok_in    (tin),
                .word      (cell_word[j]),
                .tok_out   (chain[j])
            );
        end
    endgenerate

    assign last_tok  = chain[stk_pkg::DEPTH-1];
    assign found_pos = count_reg - {1'b0, last_tok.idx} - 1'b1;

    always_comb
    begin
        count_next = count_reg;
        if (push_ok)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop_ok)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        if (launch)
        begin
            busy_next = 1'b1;
        end
        else if (last_tok.valid)
        begin
            busy_next = 1'b0;
        end
    end

    always_comb
    begin
        done_next   = 1'b0;
        status_next = status_reg;
        data_next   = data_reg;
        found_next  = found_reg;
        occ_next    = occ_reg;
        if (last_tok.valid)
        begin
            done_next   = 1'b1;
            occ_next    = count_reg;
            status_next = stk_pkg::ST_OK;
            data_next   = '0;
            found_next  = '0;
            if (last_tok.is_search)
            begin
                if (last_tok.hit)
                begin
                    found_next = found_pos[stk_pkg::POS_W-1:0];
                end
                else
                begin
                    status_next = stk_pkg::ST_NOTFOUND;
                end
            end
            else
            begin
                data_next = last_tok.word;
            end
        end
        else if (accept && !launch)
        begin
            done_next   = 1'b1;
            occ_next    = count_next;
            status_next = stk_pkg::ST_OK;
            data_next   = '0;
            found_next  = '0;
            unique case (action)
                stk_pkg::ACT_PUSH:
                begin
                    if (!push_ok)
                    begin
                        status_next = stk_pkg::ST_FULL;
                    end
                end
                stk_pkg::ACT_POP:
                begin
                    if (pop_ok)
                    begin
                        data_next = cell_word[0];
                    end
                    else
                    begin
                        status_next = stk_pkg::ST_EMPTY;
                    end
                end
                stk_pkg::ACT_READ:
                begin
                    status_next = stk_pkg::ST_RANGE;
                end
                stk_pkg::ACT_SEARCH:
                begin
                    status_next = stk_pkg::ST_NOTFOUND;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        data_reg   <= data_next;
        found_reg  <= found_next;
        occ_reg    <= occ_next;
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign status    = status_reg;
    assign data_out  = data_reg;
    assign found_at  = found_reg;
    assign occupancy = occ_reg;

    `STK_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= DEPTH_C, "entry count above depth")
    `STK_ASSERT_NEXT(a_pushpop_done, accept && !action[1], done && !busy,
        "push or pop transaction without result in next cycle")
    `STK_ASSERT_NEXT(a_search_busy, accept && (action == stk_pkg::ACT_SEARCH), busy && !done,
        "search transaction did not hold off input")
    `STK_ASSERT_NOW(a_notfound_zero, done && (status == stk_pkg::ST_NOTFOUND),
        (found_at == '0) && (data_out == '0), "failed search with nonzero payload")

endmodule

// ===== design/stk_cell.sv =====
module stk_cell (
    input  logic                       clk,
    input  logic                       rst_n,
    input  stk_pkg::ctl_t              ctl,
    input  logic [stk_pkg::WORD_W-1:0] up_word,
    input  logic [stk_pkg::WORD_W-1:0] down_word,
    input  logic [stk_pkg::POS_W-1:0]  cell_idx,
    input  logic [stk_pkg::CNT_W-1:0]  count,
    input  stk_pkg::tok_t              tok_in,
    output logic [stk_pkg::WORD_W-1:0] word,
    output stk_pkg::tok_t              tok_out
);

    logic [stk_pkg::WORD_W-1:0] word_reg;
    stk_pkg::tok_t              tok_reg;
    stk_pkg::tok_t              tok_next;
    logic                       in_use;

    assign in_use = {1'b0, cell_idx} < count;

    always_comb
    begin
        tok_next = tok_in;
        if (tok_in.valid)
        begin
            if (tok_in.is_search)
            begin
                // later cells sit lower in the stack, so the last hit wins
                if (in_use && (tok_in.word == word_reg))
                begin
                    tok_next.hit = 1'b1;
                    tok_next.idx = cell_idx;
                end
            end
            else if (tok_in.target == cell_idx)
            begin
                tok_next.word = word_reg;
                tok_next.hit  = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.push)
        begin
            word_reg <= up_word;
        end
        else if (ctl.pop)
        begin
            word_reg <= down_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    assign word    = word_reg;
    assign tok_out = tok_reg;

endmodule

// ===== design/stk_apb.sv =====
module stk_apb (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [stk_pkg::ADDR_W-1:0]  paddr,
    input  logic [stk_pkg::PDATA_W-1:0] pwdata,
    output logic [stk_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    output logic [stk_pkg::CNT_W-1:0]   capacity
);

    logic [stk_pkg::CNT_W-1:0] capacity_reg;
    logic                      sel_cap;

    assign pready  = 1'b1;
    assign sel_cap = (paddr[stk_pkg::ADDR_W-1] == stk_pkg::REG_CAPACITY[stk_pkg::ADDR_W-1]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= stk_pkg::CAP_RESET;
        end
        else if (psel && penable && pwrite && pready && sel_cap)
        begin
            capacity_reg <= pwdata[stk_pkg::CNT_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (sel_cap)
        begin
            prdata = {{(stk_pkg::PDATA_W-stk_pkg::CNT_W){1'b0}}, capacity_reg};
        end
    end

    assign capacity = capacity_reg;

endmodule

// ===== tb/sv/stack_with_index_read_and_search_unit_test.sv =====
module stack_with_index_read_and_search_unit_test;

    localparam int LIMIT_CYCLES = 1500000;
    localparam int SHOWN_MAX    = 10;

    typedef struct packed {
        logic [stk_pkg::STAT_W-1:0] status;
        logic [stk_pkg::WORD_W-1:0] data;
        logic [stk_pkg::POS_W-1:0]  found;
        logic [stk_pkg::CNT_W-1:0]  occ;
    } stack_result_t;

    logic                                clk;
    logic                                rst_n;
    logic                                start;
    logic                                busy;
    logic [stk_pkg::ACT_W-1:0]           action;
    logic signed [stk_pkg::WORD_W-1:0]   value;
    logic [stk_pkg::POS_W-1:0]           position;
    logic                                done;
    logic [stk_pkg::STAT_W-1:0]          status;
    logic signed [stk_pkg::WORD_W-1:0]   data_out;
    logic [stk_pkg::POS_W-1:0]           found_at;
    logic [stk_pkg::CNT_W-1:0]           occupancy;
    logic                                psel;
    logic                                penable;
    logic                                pwrite;
    logic [stk_pkg::ADDR_W-1:0]          paddr;
    logic [stk_pkg::PDATA_W-1:0]         pwdata;
    logic [stk_pkg::PDATA_W-1:0]         prdata;
    logic                                pready;

    // stack shadow
    logic [stk_pkg::WORD_W-1:0]  model_words [stk_pkg::DEPTH];
    int unsigned                 model_count;
    logic [stk_pkg::CNT_W-1:0]   model_capacity;
    stack_result_t               pending_results [$];
    logic [stk_pkg::WORD_W-1:0]  value_pool [8];
    int                          mismatch_count;
    int                          cycle_count;
    bit                          no_idle;

    stack_with_index_read_and_search_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .action    (action),
        .value     (value),
        .position  (position),
        .done      (done),
        .status    (status),
        .data_out  (data_out),
        .found_at  (found_at),
        .occupancy (occupancy),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic note_mismatch(input string what, input logic [31:0] expv,
                                 input logic [31:0] gotv);
        mismatch_count++;
        if (mismatch_count <= SHOWN_MAX)
            $display("mismatch %s: expected %h, got %h", what, expv, gotv);
    endtask

    function automatic stack_result_t predict_stack(
        input logic [stk_pkg::ACT_W-1:0]  act,
        input logic [stk_pkg::WORD_W-1:0] word,
        input logic [stk_pkg::POS_W-1:0]  pos);
        stack_result_t r;
        int unsigned   limit;
        r = '0;
        r.status = stk_pkg::ST_OK;
        limit = (model_capacity > stk_pkg::DEPTH) ? stk_pkg::DEPTH : model_capacity;
        unique case (act)
            stk_pkg::ACT_PUSH:
            begin
                if (model_count < limit)
                begin
                    model_words[model_count] = word;
                    model_count++;
                end
                else
                    r.status = stk_pkg::ST_FULL;
            end
            stk_pkg::ACT_POP:
            begin
                if (model_count > 0)
                begin
                    model_count--;
                    r.data = model_words[model_count];
                end
                else
                    r.status = stk_pkg::ST_EMPTY;
            end
            stk_pkg::ACT_READ:
            begin
                if (pos < model_count)
                    r.data = model_words[pos];
                else
                    r.status = stk_pkg::ST_RANGE;
            end
            stk_pkg::ACT_SEARCH:
            begin
                r.status = stk_pkg::ST_NOTFOUND;
                for (int i = 0; i < model_count; i++)
                begin
                    if (model_words[i] == word)
                    begin
                        r.status = stk_pkg::ST_OK;
                        r.found  = stk_pkg::POS_W'(i);
                        break;
                    end
                end
            end
        endcase
        r.occ = model_count[stk_pkg::CNT_W-1:0];
        return r;
    endfunction

    // result checker
    always @(posedge clk)
    begin
        stack_result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
                note_mismatch("unexpected result status", '0, 32'(status));
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.status)
                    note_mismatch("status", 32'(want.status), 32'(status));
                if (data_out !== want.data)
                    note_mismatch("data_out", want.data, data_out);
                if (found_at !== want.found)
                    note_mismatch("found_at", 32'(want.found), 32'(found_at));
                if (occupancy !== want.occ)
                    note_mismatch("occupancy", 32'(want.occ), 32'(occupancy));
            end
        end
    end

    task automatic issue_request(input logic [stk_pkg::ACT_W-1:0]  act,
                                 input logic [stk_pkg::WORD_W-1:0] word,
                                 input logic [stk_pkg::POS_W-1:0]  pos);
        @(negedge clk);
        start    <= 1'b1;
        action   <= act;
        value    <= word;
        position <= pos;
        do @(posedge clk); while (busy);
        pending_results.push_back(predict_stack(act, word, pos));
    endtask

    task automatic pause_sender(input int n);
        if (n > 0)
        begin
            @(negedge clk);
            start    <= 1'b0;
            action   <= stk_pkg::ACT_W'($urandom());
            value    <= $urandom();
            position <= stk_pkg::POS_W'($urandom());
            repeat (n - 1) @(negedge clk);
        end
    endtask

    task automatic drain_results();
        pause_sender(1);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic check_capacity_readback(input logic [stk_pkg::CNT_W-1:0] cap);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= stk_pkg::REG_CAPACITY;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== stk_pkg::PDATA_W'(cap))
            note_mismatch("capacity readback", stk_pkg::PDATA_W'(cap), prdata);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic write_capacity(input logic [stk_pkg::CNT_W-1:0] cap);
        logic [stk_pkg::PDATA_W-1:0] w;
        w = $urandom();
        w[stk_pkg::CNT_W-1:0] = cap;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= stk_pkg::REG_CAPACITY;
        pwdata  <= w;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        model_capacity = cap;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        check_capacity_readback(cap);
    endtask

    function automatic int sender_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [stk_pkg::WORD_W-1:0] pick_value();
        unique case ($urandom_range(0, 9))
            0:
            begin
                unique case ($urandom_range(0, 3))
                    0: return 32'h7fff_ffff;
                    1: return 32'h8000_0000;
                    2: return 32'h0000_0000;
                    default: return 32'hffff_ffff;
                endcase
            end
            1, 2, 3: return value_pool[$urandom_range(0, 7)];
            default: return $urandom();
        endcase
    endfunction

    task automatic run_random(input int items, input int push_pct, input int pop_pct,
                              input int read_pct);
        int                         r;
        logic [stk_pkg::ACT_W-1:0]  act;
        logic [stk_pkg::WORD_W-1:0] word;
        logic [stk_pkg::POS_W-1:0]  pos;
        for (int k = 0; k < items; k++)
        begin
            if (k % 40 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (r < push_pct)
                act = stk_pkg::ACT_PUSH;
            else if (r < push_pct + pop_pct)
                act = stk_pkg::ACT_POP;
            else if (r < push_pct + pop_pct + read_pct)
                act = stk_pkg::ACT_READ;
            else
                act = stk_pkg::ACT_SEARCH;
            word = pick_value();
            pos  = stk_pkg::POS_W'($urandom_range(0, 255));
            if (act == stk_pkg::ACT_SEARCH && model_count > 0 && $urandom_range(0, 9) < 6)
                word = model_words[$urandom_range(0, model_count - 1)];
            if (act == stk_pkg::ACT_READ && model_count > 0 && $urandom_range(0, 3) != 0)
                pos = stk_pkg::POS_W'($urandom_range(0, model_count - 1));
            issue_request(act, word, pos);
            if ($urandom_range(0, 199) == 0)
                drain_results();
            else if (!no_idle)
                pause_sender(sender_gap());
        end
        drain_results();
    endtask

    task automatic test_empty_stack();
        issue_request(stk_pkg::ACT_POP, $urandom(), stk_pkg::POS_W'($urandom()));
        issue_request(stk_pkg::ACT_READ, $urandom(), 8'd0);
        issue_request(stk_pkg::ACT_SEARCH, 32'd0, stk_pkg::POS_W'($urandom()));
        drain_results();
    endtask

    task automatic test_push_extremes();
        issue_request(stk_pkg::ACT_PUSH, 32'h7fff_ffff, stk_pkg::POS_W'($urandom()));
        issue_request(stk_pkg::ACT_PUSH, 32'h8000_0000, stk_pkg::POS_W'($urandom()));
        issue_request(stk_pkg::ACT_PUSH, 32'h0000_0000, stk_pkg::POS_W'($urandom()));
        issue_request(stk_pkg::ACT_PUSH, 32'hffff_ffff, stk_pkg::POS_W'($urandom()));
        issue_request(stk_pkg::ACT_PUSH, 32'h7fff_ffff, stk_pkg::POS_W'($urandom()));
        issue_request(stk_pkg::ACT_READ, $urandom(), 8'd0);
        issue_request(stk_pkg::ACT_READ, $urandom(), 8'd4);
        issue_request(stk_pkg::ACT_READ, $urandom(), 8'd5);
        issue_request(stk_pkg::ACT_READ, $urandom(), 8'd255);
        issue_request(stk_pkg::ACT_SEARCH, 32'h7fff_ffff, stk_pkg::POS_W'($urandom()));
        issue_request(stk_pkg::ACT_SEARCH, 32'h8000_0000, stk_pkg::POS_W'($urandom()));
        issue_request(stk_pkg::ACT_SEARCH, 32'h0001_2345, stk_pkg::POS_W'($urandom()));
        drain_results();
    endtask

    task automatic test_capacity_zero();
        write_capacity(9'd0);
        issue_request(stk_pkg::ACT_PUSH, $urandom(), stk_pkg::POS_W'($urandom()));
        issue_request(stk_pkg::ACT_POP, $urandom(), stk_pkg::POS_W'($urandom()));
        drain_results();
    endtask

    // capacity set below the current count
    task automatic test_capacity_below_count();
        write_capacity(9'd1);
        issue_request(stk_pkg::ACT_PUSH, $urandom(), stk_pkg::POS_W'($urandom()));
        issue_request(stk_pkg::ACT_READ, $urandom(), 8'd3);
        issue_request(stk_pkg::ACT_SEARCH, 32'hffff_ffff, stk_pkg::POS_W'($urandom()));
        issue_request(stk_pkg::ACT_POP, $urandom(), stk_pkg::POS_W'($urandom()));
        drain_results();
    endtask

    // capacity above depth is clamped
    task automatic test_fill_to_depth();
        write_capacity(9'd511);
        run_random(370, 85, 5, 5);
    endtask

    task automatic test_empty_out();
        write_capacity(stk_pkg::CAP_RESET);
        run_random(330, 5, 85, 5);
    endtask

    task automatic test_small_capacities();
        logic [stk_pkg::CNT_W-1:0] caps [6];
        caps = '{9'd1, 9'd2, 9'd3, 9'd5, 9'd8, 9'd0};
        caps[5] = stk_pkg::CNT_W'($urandom_range(9, 40));
        foreach (caps[i])
        begin
            write_capacity(caps[i]);
            run_random(50, 40, 30, 15);
        end
    endtask

    task automatic test_mixed_capacity();
        for (int p = 0; p < 3; p++)
        begin
            write_capacity(stk_pkg::CNT_W'($urandom_range(1, 511)));
            run_random(40, 45, 30, 12);
        end
    endtask

    initial
    begin
        rst_n    = 1'b0;
        start    = 1'b0;
        action   = '0;
        value    = '0;
        position = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        mismatch_count = 0;
        cycle_count    = 0;
        no_idle        = 1'b0;
        model_count    = 0;
        model_capacity = stk_pkg::CAP_RESET;
        foreach (value_pool[i])
            value_pool[i] = $urandom();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        check_capacity_readback(stk_pkg::CAP_RESET);
        test_empty_stack();
        test_push_extremes();
        test_capacity_zero();
        test_capacity_below_count();
        test_fill_to_depth();
        test_empty_out();
        test_small_capacities();
        test_mixed_capacity();

        drain_results();
        repeat (300) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
